// File: rtl/core/lpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpd_pkg: shared types and constants for the length-prefixed deframer
// Holds the header layout constants, the parser phase type and the
// result item structure passed from the parser to the output stage.
// ----------------------------------------------------------------------------
package lpd_pkg;

    // Header layout: 4 length bytes then 4 id bytes, little-endian
    localparam int unsigned HDR_BYTES = 8;
    localparam int unsigned HIDX_W    = $clog2(HDR_BYTES);
    localparam logic [HIDX_W-1:0] HDR_LAST = HIDX_W'(HDR_BYTES - 1);

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 32;

    // Parser phase, one-hot
    typedef enum logic [1:0] {
        PH_HEADER  = 2'b01,
        PH_PAYLOAD = 2'b10
    } lpd_phase_t;

    // One result item
    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [WORD_W-1:0] message_id;
        logic [WORD_W-1:0] message_length;
        logic              first_of_message;
        logic              last_of_message;
        logic              empty_message;
    } lpd_result_t;

    // Replace one byte lane of a 32-bit word
    function automatic logic [WORD_W-1:0] put_lane(
        input logic [WORD_W-1:0] word,
        input logic [1:0]        lane,
        input logic [BYTE_W-1:0] b
    );
        logic [WORD_W-1:0] w;
        begin
            w = word;
            case (lane)
                2'd0:    w[7:0]   = b;
                2'd1:    w[15:8]  = b;
                2'd2:    w[23:16] = b;
                default: w[31:24] = b;
            endcase
            return w;
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/lpd_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpd_in_stage: input register
// Captures one byte item per cycle and holds it until the parser
// consumes it; stalls the sender only while the held item cannot move.
// ----------------------------------------------------------------------------
module lpd_in_stage (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [lpd_pkg::BYTE_W-1:0] in_byte,
    input  wire logic                      out_ready,
    output logic                           advance,
    output logic [lpd_pkg::BYTE_W-1:0]     s1_byte
);
    import lpd_pkg::*;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              load;

    // Move the held item on when the output side has room
    assign advance  = s1_valid_reg && out_ready;
    assign in_stall = s1_valid_reg && !out_ready;
    assign load     = in_valid && !in_stall;
    assign s1_byte  = s1_byte_reg;

    always_comb
    begin
        if (load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // Hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Capture payload byte
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_byte_reg <= in_byte;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/lpd_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpd_parser: header assembly and payload countdown
// Holds the framing state, builds length and id from header bytes and
// tags each payload byte; produces at most one result per consumed item.
// ----------------------------------------------------------------------------
module lpd_parser (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire logic [lpd_pkg::BYTE_W-1:0] s1_byte,
    output logic                            res_valid,
    output lpd_pkg::lpd_result_t            res
);
    import lpd_pkg::*;

    lpd_phase_t        phase_reg;
    lpd_phase_t        phase_next;
    logic [HIDX_W-1:0] header_index_reg;
    logic [HIDX_W-1:0] header_index_next;
    logic [WORD_W-1:0] length_reg;
    logic [WORD_W-1:0] length_next;
    logic [WORD_W-1:0] id_reg;
    logic [WORD_W-1:0] id_next;
    logic [WORD_W-1:0] remaining_reg;
    logic [WORD_W-1:0] remaining_next;
    logic              first_pending_reg;
    logic              first_pending_next;
    logic              last_byte;

    assign last_byte = (remaining_reg <= WORD_W'(1));

    // Decide next state and the result for the item being consumed
    always_comb
    begin
        phase_next         = phase_reg;
        header_index_next  = header_index_reg;
        length_next        = length_reg;
        id_next            = id_reg;
        remaining_next     = remaining_reg;
        first_pending_next = first_pending_reg;
        res_valid          = 1'b0;
        res                = '0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (header_index_reg[HIDX_W-1])
                begin
                    id_next = put_lane(id_reg, header_index_reg[1:0], s1_byte);
                end
                else
                begin
                    length_next = put_lane(length_reg, header_index_reg[1:0], s1_byte);
                end

                if (header_index_reg != HDR_LAST)
                begin
                    header_index_next = header_index_reg + HIDX_W'(1);
                end
                else
                begin
                    header_index_next = '0;
                    if (length_reg == '0)
                    begin
                        // Zero-length message: one empty result
                        res_valid            = advance;
                        res.message_id       = id_next;
                        res.message_length   = length_reg;
                        res.first_of_message = 1'b1;
                        res.last_of_message  = 1'b1;
                        res.empty_message    = 1'b1;
                    end
                    else
                    begin
                        phase_next         = PH_PAYLOAD;
                        remaining_next     = length_reg;
                        first_pending_next = 1'b1;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                res_valid            = advance;
                res.payload_byte     = s1_byte;
                res.message_id       = id_reg;
                res.message_length   = length_reg;
                res.first_of_message = first_pending_reg;
                res.last_of_message  = last_byte;
                first_pending_next   = 1'b0;
                if (last_byte)
                begin
                    remaining_next = '0;
                    phase_next     = PH_HEADER;
                end
                else
                begin
                    remaining_next = remaining_reg - WORD_W'(1);
                end
            end
            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase
    end

    // Advance state only when an item is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HEADER;
            header_index_reg  <= '0;
            length_reg        <= '0;
            id_reg            <= '0;
            remaining_reg     <= '0;
            first_pending_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            header_index_reg  <= header_index_next;
            length_reg        <= length_next;
            id_reg            <= id_next;
            remaining_reg     <= remaining_next;
            first_pending_reg <= first_pending_next;
        end
    end

`ifndef ASSERT_OFF
    a_payload_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (remaining_reg != '0))
        else $error("payload phase with zero bytes remaining");

    a_payload_header_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (header_index_reg == '0))
        else $error("header index moved during payload");

    a_empty_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.empty_message) |->
            (res.first_of_message && res.last_of_message && res.payload_byte == '0
             && res.message_length == '0))
        else $error("empty result with wrong marks");

    a_last_ends_message: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == PH_PAYLOAD && remaining_reg == WORD_W'(1))
            |=> (phase_reg == PH_HEADER))
        else $error("final payload byte did not return to header");
`endif

endmodule
`default_nettype wire

// File: rtl/core/lpd_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpd_out_stage: result register
// Holds one result item for the receiver; accepts a new one in the same
// cycle the held one is taken.
// ----------------------------------------------------------------------------
module lpd_out_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 res_valid,
    input  wire lpd_pkg::lpd_result_t res,
    input  wire logic                 out_stall,
    output logic                      out_ready,
    output logic                      out_valid,
    output lpd_pkg::lpd_result_t      out_res
);
    import lpd_pkg::*;

    logic        out_valid_reg;
    logic        out_valid_next;
    lpd_result_t out_res_reg;

    // Room when empty or the held item leaves this cycle
    assign out_ready = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    assign out_valid_next = res_valid || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load a new result
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_res_reg <= res;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/length_prefixed_deframer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_deframer_top: byte-stream message deframer
// Cuts a byte stream into length-prefixed messages and tags each payload
// byte with the message id, length and first/last/empty marks.
//
// Input channel: in_valid/in_stall carry one stream byte per item on
// in_byte. Each message is an 8-byte header (4-byte little-endian length,
// then 4-byte little-endian id) followed by its payload bytes.
// Output channel: out_valid/out_stall carry one result item per payload
// byte; a zero-length message gives one item with empty_message set,
// both first and last marks set and payload_byte zero. Header bytes give
// no result.
// Each accepted byte is loaded into the input register and then, while the
// receiver takes results, goes through the parser into the result register,
// which drives the outputs. Throughput: one byte per cycle while the receiver
// does not stall; the framing update is combinational with no loop.
// Reset (rst_n low) clears both stages and returns the parser to expect a
// header with length and id zero.
// When the receiver stalls, the result register holds its item; the input
// register then fills and in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module length_prefixed_deframer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       payload_byte,
    output logic [31:0]      message_id,
    output logic [31:0]      message_length,
    output logic             first_of_message,
    output logic             last_of_message,
    output logic             empty_message
);
    import lpd_pkg::*;

    logic              out_ready;
    logic              advance;
    logic [BYTE_W-1:0] s1_byte;
    logic              res_valid;
    lpd_result_t       res;
    lpd_result_t       out_res;

    lpd_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_ready (out_ready),
        .advance   (advance),
        .s1_byte   (s1_byte)
    );

    lpd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .s1_byte   (s1_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    lpd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_stall (out_stall),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    // Unpack the held result onto the ports
    assign payload_byte     = out_res.payload_byte;
    assign message_id       = out_res.message_id;
    assign message_length   = out_res.message_length;
    assign first_of_message = out_res.first_of_message;
    assign last_of_message  = out_res.last_of_message;
    assign empty_message    = out_res.empty_message;

endmodule
`default_nettype wire

// File: bench/length_prefixed_deframer_top_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_deframer_top_test: self-checking bench for the deframer
// Feeds a byte stream of length-prefixed messages into the block. A local
// framing predictor follows the stream and builds the expected result
// items. A monitor compares every result taken from the block, field by
// field, against the oldest expected item. Both channels idle and stall at
// random, the receiver holds off once for a long stretch, and the sender
// waits for the results to drain before some messages.
// ----------------------------------------------------------------------------
module length_prefixed_deframer_top_test;

    import lpd_pkg::*;

    // One stream byte waiting to be sent; drain_first holds it back until
    // every expected result has come out of the block
    typedef struct {
        logic [7:0] value;
        bit         drain_first;
    } stream_byte_t;

    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_BYTES   = 1600;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte   = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  payload_byte;
    logic [31:0] message_id;
    logic [31:0] message_length;
    logic        first_of_message;
    logic        last_of_message;
    logic        empty_message;

    // Stimulus and expected results
    stream_byte_t stream_q[$];
    lpd_result_t  expected_results[$];

    // Predictor state
    lpd_phase_t        parse_phase = PH_HEADER;
    logic [HIDX_W-1:0] hdr_pos     = '0;
    logic [31:0]       hdr_length  = '0;
    logic [31:0]       hdr_id      = '0;
    logic [31:0]       bytes_left  = '0;
    logic              first_due   = 1'b0;

    // Idling controls
    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    int tx_idle      = 0;
    int rx_idle      = 0;
    bit rx_hold      = 1'b0;

    // Counters
    int error_count    = 0;
    int bytes_accepted = 0;
    int results_seen   = 0;
    int messages_seen  = 0;
    int empties_seen   = 0;

    length_prefixed_deframer_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_byte          (in_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .payload_byte     (payload_byte),
        .message_id       (message_id),
        .message_length   (message_length),
        .first_of_message (first_of_message),
        .last_of_message  (last_of_message),
        .empty_message    (empty_message)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Idle length: mostly short, a few long
    function automatic int idle_len();
        int pick;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
                return $urandom_range(1, 3);
            else if (pick < 97)
                return $urandom_range(4, 12);
            else
                return $urandom_range(20, 80);
        end
    endfunction

    // Report one mismatch and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            error_count++;
            if (error_count <= 50)
                $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                         $time, what, got, want);
        end
    endtask

    // Track framing for one accepted stream byte and queue the result it gives
    task automatic deframe_byte(input logic [7:0] b);
        lpd_result_t r;
        begin
            r = '0;
            if (parse_phase == PH_HEADER)
            begin
                // Overwrite this byte's lane of the length or the id
                if (hdr_pos < HIDX_W'(4))
                    hdr_length[{hdr_pos[1:0], 3'b000} +: 8] = b;
                else
                    hdr_id[{hdr_pos[1:0], 3'b000} +: 8] = b;
                if (hdr_pos != HDR_LAST)
                begin
                    hdr_pos = hdr_pos + HIDX_W'(1);
                end
                else
                begin
                    hdr_pos = '0;
                    if (hdr_length == 32'd0)
                    begin
                        // Zero-length message: one empty item right away
                        r.message_id       = hdr_id;
                        r.first_of_message = 1'b1;
                        r.last_of_message  = 1'b1;
                        r.empty_message    = 1'b1;
                        expected_results.insert(expected_results.size(), r);
                    end
                    else
                    begin
                        parse_phase = PH_PAYLOAD;
                        bytes_left  = hdr_length;
                        first_due   = 1'b1;
                    end
                end
            end
            else
            begin
                // Payload byte: tag it and count down
                r.payload_byte     = b;
                r.message_id       = hdr_id;
                r.message_length   = hdr_length;
                r.first_of_message = first_due;
                r.last_of_message  = (bytes_left <= 32'd1);
                expected_results.insert(expected_results.size(), r);
                first_due = 1'b0;
                if (bytes_left <= 32'd1)
                begin
                    bytes_left  = '0;
                    parse_phase = PH_HEADER;
                end
                else
                begin
                    bytes_left = bytes_left - 32'd1;
                end
            end
        end
    endtask

    // Compare one taken result item with the oldest expectation
    task automatic check_result();
        lpd_result_t want;
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with nothing expected", 32'(payload_byte), 32'd0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (payload_byte !== want.payload_byte)
                    report_mismatch("payload_byte", 32'(payload_byte),
                                    32'(want.payload_byte));
                if (message_id !== want.message_id)
                    report_mismatch("message_id", message_id, want.message_id);
                if (message_length !== want.message_length)
                    report_mismatch("message_length", message_length, want.message_length);
                if (first_of_message !== want.first_of_message)
                    report_mismatch("first_of_message", 32'(first_of_message),
                                    32'(want.first_of_message));
                if (last_of_message !== want.last_of_message)
                    report_mismatch("last_of_message", 32'(last_of_message),
                                    32'(want.last_of_message));
                if (empty_message !== want.empty_message)
                    report_mismatch("empty_message", 32'(empty_message),
                                    32'(want.empty_message));
                if (want.last_of_message)
                    messages_seen++;
                if (want.empty_message)
                    empties_seen++;
            end
        end
    endtask

    task automatic push_byte(input logic [7:0] value, input bit drain_first);
        stream_byte_t s;
        begin
            s.value       = value;
            s.drain_first = drain_first;
            stream_q.insert(stream_q.size(), s);
        end
    endtask

    // Queue a header (length then id, little-endian) and random payload bytes
    task automatic queue_message(input logic [31:0] len, input logic [31:0] id,
                                 input int n_payload, input bit drain_first);
        begin
            for (int k = 0; k < 4; k++)
                push_byte(len[8*k +: 8], drain_first && (k == 0));
            for (int k = 0; k < 4; k++)
                push_byte(id[8*k +: 8], 1'b0);
            for (int k = 0; k < n_payload; k++)
                push_byte(8'($urandom), 1'b0);
        end
    endtask

    // Driver: offer the next stream byte, hold it while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= 8'h00;
            tx_idle  <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                deframe_byte(in_byte);
                bytes_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (tx_idle > 0)
                begin
                    in_valid <= 1'b0;
                    tx_idle  <= tx_idle - 1;
                end
                else if (stream_q.size() == 0 ||
                         (stream_q[0].drain_first && expected_results.size() != 0))
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_byte  <= stream_q[0].value;
                    void'(stream_q.pop_front());
                    if ($urandom_range(0, 99) < tx_gap_pct)
                        tx_idle <= idle_len();
                end
            end
        end
    end

    // Monitor: take and check results, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_idle   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (rx_hold)
            begin
                out_stall <= 1'b1;
            end
            else if (rx_idle > 0)
            begin
                out_stall <= 1'b1;
                rx_idle   <= rx_idle - 1;
            end
            else if ($urandom_range(0, 99) < rx_stall_pct)
            begin
                out_stall <= 1'b1;
                rx_idle   <= idle_len() - 1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Change the idling mix now and then, with quiet stretches among them
    initial
    begin
        forever
        begin
            repeat ($urandom_range(100, 400)) @(posedge clk);
            case ($urandom_range(0, 3))
                0:
                begin
                    tx_gap_pct   <= 0;
                    rx_stall_pct <= 0;
                end
                1:
                begin
                    tx_gap_pct   <= 20;
                    rx_stall_pct <= 20;
                end
                2:
                begin
                    tx_gap_pct   <= 50;
                    rx_stall_pct <= 10;
                end
                default:
                begin
                    tx_gap_pct   <= 10;
                    rx_stall_pct <= 50;
                end
            endcase
        end
    end

    // Hold off the receiver for a long stretch while the sender keeps going
    initial
    begin
        while (bytes_accepted < 700)
            @(posedge clk);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Stop a hung run
    initial
    begin
        #20_000_000;
        $display("Timeout: %0d results still expected", expected_results.size());
        $display("== FAIL ==");
        $finish;
    end

    // Build the stream, reset, then wait for everything to drain
    initial
    begin
        int len;
        int pick;
        int msg_n;

        // Empty message with an all-ones id
        queue_message(32'd0, 32'hFFFF_FFFF, 0, 1'b0);
        // One-byte message, id zero, payload all ones
        queue_message(32'd1, 32'h0000_0000, 0, 1'b0);
        push_byte(8'hFF, 1'b0);
        // Two-byte message, payload zero then top bit only
        queue_message(32'd2, 32'h80C3_5A01, 0, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0);

        // Random messages, mostly short
        msg_n = 0;
        while (stream_q.size() < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                len = 0;
            else if (pick < 30)
                len = 1;
            else if (pick < 80)
                len = $urandom_range(2, 12);
            else if (pick < 95)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(41, 120);
            queue_message(len, $urandom, len,
                          (msg_n % 50 == 25) || ($urandom_range(0, 99) < 3));
            msg_n++;
        end

        // Largest length last: it never completes, so only counting down
        queue_message(32'hFFFF_FFFF, $urandom, 40, 1'b1);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (stream_q.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d stream bytes; checked %0d results over %0d complete messages",
                 bytes_accepted, results_seen, messages_seen);
        $display("Empty messages %0d, receiver hold-off %0d cycles, mismatches %0d",
                 empties_seen, RX_HOLD_CYCLES, error_count);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
